// ===== rtl/u2cp_pkg.sv =====
`default_nettype none
package u2cp_pkg;

	localparam logic [7:0] QMARK = 8'h3f;
	localparam logic [7:0] ASCII_TOP = 8'h80;
	localparam logic [7:0] LEAD2_MIN = 8'hc2;
	localparam logic [7:0] LEAD3_MIN = 8'he0;
	localparam logic [7:0] LEAD3_FULL = 8'he1;
	localparam logic [7:0] LEAD4_MIN = 8'hf0;
	localparam logic [7:0] E0_CONT_MIN = 8'ha0;
	localparam int FIFO_DEPTH = 4;

	// mode register values
	localparam logic MODE_LATIN2 = 1'b0;
	localparam logic MODE_UTF8 = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       text_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
	} out_item_t;

	// one pending result: a code point to map, or a finished CP1250 byte
	typedef struct packed {
		logic        raw;
		logic [15:0] val;
	} res_t;

	// all results caused by one input item
	typedef struct packed {
		logic [1:0]     cnt;
		logic           text_end;
		res_t [2:0]     res;
	} group_t;

	localparam res_t RES_QMARK = '{raw: 1'b1, val: {8'h00, QMARK}};

	localparam logic [15:0] CP1250_POINTS [128] = '{
		16'h20ac, 16'h003f, 16'h201a, 16'h003f, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
		16'h003f, 16'h2030, 16'h0160, 16'h2039, 16'h015a, 16'h0164, 16'h017d, 16'h0179,
		16'h003f, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
		16'h003f, 16'h2122, 16'h0161, 16'h203a, 16'h015b, 16'h0165, 16'h017e, 16'h017a,
		16'h00a0, 16'h02c7, 16'h02d8, 16'h0141, 16'h00a4, 16'h0104, 16'h00a6, 16'h00a7,
		16'h00a8, 16'h00a9, 16'h015e, 16'h00ab, 16'h00ac, 16'h00ad, 16'h00ae, 16'h017b,
		16'h00b0, 16'h00b1, 16'h02db, 16'h0142, 16'h00b4, 16'h00b5, 16'h00b6, 16'h00b7,
		16'h00b8, 16'h0105, 16'h015f, 16'h00bb, 16'h013d, 16'h02dd, 16'h013e, 16'h017c,
		16'h0154, 16'h00c1, 16'h00c2, 16'h0102, 16'h00c4, 16'h0139, 16'h0106, 16'h00c7,
		16'h010c, 16'h00c9, 16'h0118, 16'h00cb, 16'h011a, 16'h00cd, 16'h00ce, 16'h010e,
		16'h0110, 16'h0143, 16'h0147, 16'h00d3, 16'h00d4, 16'h0150, 16'h00d6, 16'h00d7,
		16'h0158, 16'h016e, 16'h00da, 16'h0170, 16'h00dc, 16'h00dd, 16'h0162, 16'h00df,
		16'h0155, 16'h00e1, 16'h00e2, 16'h0103, 16'h00e4, 16'h013a, 16'h0107, 16'h00e7,
		16'h010d, 16'h00e9, 16'h0119, 16'h00eb, 16'h011b, 16'h00ed, 16'h00ee, 16'h010f,
		16'h0111, 16'h0144, 16'h0148, 16'h00f3, 16'h00f4, 16'h0151, 16'h00f6, 16'h00f7,
		16'h0159, 16'h016f, 16'h00fa, 16'h0171, 16'h00fc, 16'h00fd, 16'h0163, 16'h02d9
	};

	localparam logic [7:0] LATIN2_UPPER [32] = '{
		8'ha0, 8'ha5, 8'ha2, 8'ha3, 8'ha4, 8'hbc, 8'h8c, 8'ha7,
		8'ha8, 8'h8a, 8'haa, 8'h8d, 8'h8f, 8'had, 8'h8e, 8'haf,
		8'hb0, 8'hb9, 8'hb2, 8'hb3, 8'hb4, 8'hbe, 8'h9c, 8'ha1,
		8'hb8, 8'h9a, 8'hba, 8'h9d, 8'h9f, 8'hbd, 8'h9e, 8'hbf
	};

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	// ISO-8859-2 byte to CP1250 byte
	function automatic logic [7:0] latin2_map(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b[7:5] == 3'b100)
			r = QMARK;
		else if (b[7:5] == 3'b101)
			r = LATIN2_UPPER[b[4:0]];
		return r;
	endfunction

	// code point to CP1250 byte; lowest table index wins
	function automatic logic [7:0] cp1250_map(input logic [15:0] cp);
		logic [7:0] r;
		r = QMARK;
		if (cp < {8'h00, ASCII_TOP}) begin
			r = cp[7:0];
		end else begin
			for (int k = 127; k >= 0; k--) begin
				if (CP1250_POINTS[k] == cp)
					r = {1'b1, 7'(k)};
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/u2cp_front.sv =====
`default_nettype none
module u2cp_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	input  wire logic                 src_valid,
	input  wire u2cp_pkg::in_item_t   src_item,
	input  wire logic                 full,
	output      logic                 push,
	output      u2cp_pkg::group_t     push_data
);

	logic       mode_q;
	logic [7:0] pend_lead_q;
	logic [7:0] pend_cont_q;
	logic [1:0] pend_cnt_q;

	logic       accept;
	logic [7:0] lead_d;
	logic [7:0] cont_d;
	logic [1:0] pend_cnt_d;
	u2cp_pkg::group_t grp_d;

	assign accept = src_valid && !full;

	// decode held bytes plus the new byte into up to three results
	always_comb begin : p_decode
		logic [7:0] bytes [4];
		logic [1:0] n;
		logic [1:0] pos;
		logic [1:0] rem;
		logic [1:0] cnt;
		logic [1:0] left;
		logic       stop;
		logic [7:0] c;
		logic [7:0] b1;
		logic [7:0] b2;

		bytes[0] = src_item.in_byte;
		bytes[1] = '0;
		bytes[2] = '0;
		bytes[3] = '0;
		case (pend_cnt_q)
			2'd1: begin
				bytes[0] = pend_lead_q;
				bytes[1] = src_item.in_byte;
			end
			2'd2: begin
				bytes[0] = pend_lead_q;
				bytes[1] = pend_cont_q;
				bytes[2] = src_item.in_byte;
			end
			default: ;
		endcase
		n = (pend_cnt_q == 2'd2) ? 2'd3 : ((pend_cnt_q == 2'd1) ? 2'd2 : 2'd1);

		grp_d = '0;
		cnt = '0;
		pos = '0;
		stop = 1'b0;
		c = '0;
		b1 = '0;
		b2 = '0;
		rem = '0;

		if (mode_q == u2cp_pkg::MODE_LATIN2) begin
			// held UTF-8 bytes become '?', then the byte itself
			if (n >= 2'd2)
				grp_d.res[0] = u2cp_pkg::RES_QMARK;
			if (n == 2'd3)
				grp_d.res[1] = u2cp_pkg::RES_QMARK;
			grp_d.res[n - 2'd1] = '{raw: 1'b1,
				val: {8'h00, u2cp_pkg::latin2_map(bytes[n - 2'd1])}};
			cnt = n;
			pos = n;
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (!stop && pos < n) begin
					c = bytes[pos];
					b1 = bytes[pos + 2'd1];
					b2 = bytes[pos + 2'd2];
					rem = n - pos;
					if (c < u2cp_pkg::ASCII_TOP) begin
						grp_d.res[cnt] = '{raw: 1'b0, val: {8'h00, c}};
						cnt = cnt + 2'd1;
						pos = pos + 2'd1;
					end else if (c < u2cp_pkg::LEAD2_MIN || c >= u2cp_pkg::LEAD4_MIN) begin
						grp_d.res[cnt] = u2cp_pkg::RES_QMARK;
						cnt = cnt + 2'd1;
						pos = pos + 2'd1;
					end else if (c < u2cp_pkg::LEAD3_MIN) begin
						if (rem < 2'd2) begin
							stop = 1'b1;
						end else if (u2cp_pkg::is_cont(b1)) begin
							grp_d.res[cnt] = '{raw: 1'b0, val: {5'd0, c[4:0], b1[5:0]}};
							cnt = cnt + 2'd1;
							pos = pos + 2'd2;
						end else begin
							grp_d.res[cnt] = u2cp_pkg::RES_QMARK;
							cnt = cnt + 2'd1;
							pos = pos + 2'd1;
						end
					end else begin
						if (rem >= 2'd2 && !(u2cp_pkg::is_cont(b1) &&
								(c >= u2cp_pkg::LEAD3_FULL || b1 >= u2cp_pkg::E0_CONT_MIN))) begin
							grp_d.res[cnt] = u2cp_pkg::RES_QMARK;
							cnt = cnt + 2'd1;
							pos = pos + 2'd1;
						end else if (rem < 2'd3) begin
							stop = 1'b1;
						end else if (u2cp_pkg::is_cont(b2)) begin
							grp_d.res[cnt] = '{raw: 1'b0, val: {c[3:0], b1[5:0], b2[5:0]}};
							cnt = cnt + 2'd1;
							pos = pos + 2'd3;
						end else begin
							grp_d.res[cnt] = u2cp_pkg::RES_QMARK;
							cnt = cnt + 2'd1;
							pos = pos + 2'd1;
						end
					end
				end
			end
		end

		// end of text: every byte still held gives '?'
		if (src_item.text_end) begin
			for (int i = 0; i < 3; i++) begin
				if (pos < n) begin
					grp_d.res[cnt] = u2cp_pkg::RES_QMARK;
					cnt = cnt + 2'd1;
					pos = pos + 2'd1;
				end
			end
		end

		left = n - pos;
		if (src_item.text_end) begin
			pend_cnt_d = '0;
			lead_d = '0;
			cont_d = '0;
		end else begin
			pend_cnt_d = left;
			lead_d = (left >= 2'd1) ? bytes[pos] : 8'h00;
			cont_d = (left >= 2'd2) ? bytes[pos + 2'd1] : 8'h00;
		end

		grp_d.cnt = cnt;
		grp_d.text_end = src_item.text_end;
	end

	// mode register and held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= u2cp_pkg::MODE_UTF8;
			pend_cnt_q <= '0;
			pend_lead_q <= '0;
			pend_cont_q <= '0;
		end else begin
			if (cfg_we)
				mode_q <= cfg_wdata;
			if (accept) begin
				pend_cnt_q <= pend_cnt_d;
				pend_lead_q <= lead_d;
				pend_cont_q <= cont_d;
			end
		end
	end

	// items that only hold bytes produce nothing
	assign push = accept && (grp_d.cnt != 2'd0);
	assign push_data = grp_d;

endmodule
`default_nettype wire

// ===== rtl/u2cp_fifo.sv =====
`default_nettype none
module u2cp_fifo #(
	parameter int DEPTH = u2cp_pkg::FIFO_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire u2cp_pkg::group_t push_data,
	output      logic             full,
	input  wire logic             pop,
	output      logic             head_valid,
	output      u2cp_pkg::group_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	u2cp_pkg::group_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/u2cp_back.sv =====
`default_nettype none
module u2cp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire u2cp_pkg::group_t    head,
	output      logic                pop,
	output      logic                dst_valid,
	input  wire logic                dst_stall,
	output      u2cp_pkg::out_item_t dst_item
);

	logic [1:0] idx_q;
	logic       valid_q;
	u2cp_pkg::out_item_t item_q;

	logic           load;
	logic           last;
	u2cp_pkg::res_t cur;
	logic [7:0]     byte_d;

	// pick the next result of the head group and map it
	assign cur = head.res[idx_q];
	assign last = (idx_q == head.cnt - 2'd1);
	assign byte_d = cur.raw ? cur.val[7:0] : u2cp_pkg::cp1250_map(cur.val);
	assign load = head_valid && (!valid_q || !dst_stall);
	assign pop = load && last;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (!valid_q || !dst_stall)
				valid_q <= head_valid;
			if (load)
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q.out_byte <= byte_d;
			item_q.run_last <= last;
			item_q.text_done <= last && head.text_end;
		end
	end

	assign dst_valid = valid_q;
	assign dst_item = item_q;

endmodule
`default_nettype wire

// ===== rtl/utf8_or_latin2_to_cp1250.sv =====
// UTF-8 / ISO-8859-2 to CP1250 transcoder.
// Input channel src_*: one text byte per item plus a flag on the final byte.
// Output channel dst_*: one CP1250 byte per item; run_last marks the last
// byte caused by an input item, text_done the last byte of the whole text.
// cfg_we/cfg_wdata set the input mode (1 = UTF-8, 0 = ISO-8859-2); write it
// only while no item is in flight.
// The front end decodes one input item per cycle while the queue is not full
// (together with up to two held UTF-8 bytes) and queues the group of 0 to 3
// results it produces. The back end maps code points through the CP1250 table
// and sends one result per cycle from a registered output unless stalled.
// With an empty queue and a free output register, the group of an item is
// queued on the accepting edge, and its first result then loads dst_item.
// The block takes one input item per cycle as long as items average no more
// than one result and dst_stall stays low; the single output byte per cycle
// sets the limit, and src_stall rises when the queue of result groups is full.
// A stalled receiver holds dst_item steady; the queue absorbs input until full.
// Reset empties the queue, drops held bytes and selects UTF-8 mode.
`default_nettype none
module utf8_or_latin2_to_cp1250 #(
	parameter int FIFO_DEPTH = u2cp_pkg::FIFO_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                src_valid,
	output      logic                src_stall,
	input  wire u2cp_pkg::in_item_t  src_item,
	output      logic                dst_valid,
	input  wire logic                dst_stall,
	output      u2cp_pkg::out_item_t dst_item
);

	logic             full;
	logic             push;
	logic             pop;
	logic             head_valid;
	u2cp_pkg::group_t push_data;
	u2cp_pkg::group_t head;

	assign src_stall = full;

	u2cp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.src_valid (src_valid),
		.src_item  (src_item),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	u2cp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	u2cp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.dst_item   (dst_item)
	);

endmodule
`default_nettype wire

// ===== rtl/u2cp_checker.sv =====
`default_nettype none
module u2cp_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                src_stall,
	input wire logic                dst_valid,
	input wire logic                dst_stall,
	input wire u2cp_pkg::out_item_t dst_item
);

	// a stalled output item holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
		else $error("dst item changed while stalled");

	// end of text is always the last result of its input item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.text_done |-> dst_item.run_last)
		else $error("text_done without run_last");

	// nothing comes out right after reset
	a_reset_idle: assert property (@(posedge clk)
		$past(!arst_n) |-> !dst_valid)
		else $error("output valid right after reset");

	// an empty output stage means the queue cannot be full
	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!dst_valid |-> !src_stall)
		else $error("input stalled while output empty");

endmodule

bind utf8_or_latin2_to_cp1250 u2cp_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_stall (src_stall),
	.dst_valid (dst_valid),
	.dst_stall (dst_stall),
	.dst_item  (dst_item)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
module testbench;

	localparam logic [7:0] QMARK_BYTE = 8'h3f;
	localparam int WATCHDOG_CYCLES = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_GAP = 4;
	localparam int END_GAP = 8;
	localparam int END_PCT = 6;

	// Unicode code point of each CP1250 byte 0x80..0xFF
	localparam logic [15:0] CP1250_CODE_POINTS [128] = '{
		16'h20ac, 16'h003f, 16'h201a, 16'h003f, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
		16'h003f, 16'h2030, 16'h0160, 16'h2039, 16'h015a, 16'h0164, 16'h017d, 16'h0179,
		16'h003f, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
		16'h003f, 16'h2122, 16'h0161, 16'h203a, 16'h015b, 16'h0165, 16'h017e, 16'h017a,
		16'h00a0, 16'h02c7, 16'h02d8, 16'h0141, 16'h00a4, 16'h0104, 16'h00a6, 16'h00a7,
		16'h00a8, 16'h00a9, 16'h015e, 16'h00ab, 16'h00ac, 16'h00ad, 16'h00ae, 16'h017b,
		16'h00b0, 16'h00b1, 16'h02db, 16'h0142, 16'h00b4, 16'h00b5, 16'h00b6, 16'h00b7,
		16'h00b8, 16'h0105, 16'h015f, 16'h00bb, 16'h013d, 16'h02dd, 16'h013e, 16'h017c,
		16'h0154, 16'h00c1, 16'h00c2, 16'h0102, 16'h00c4, 16'h0139, 16'h0106, 16'h00c7,
		16'h010c, 16'h00c9, 16'h0118, 16'h00cb, 16'h011a, 16'h00cd, 16'h00ce, 16'h010e,
		16'h0110, 16'h0143, 16'h0147, 16'h00d3, 16'h00d4, 16'h0150, 16'h00d6, 16'h00d7,
		16'h0158, 16'h016e, 16'h00da, 16'h0170, 16'h00dc, 16'h00dd, 16'h0162, 16'h00df,
		16'h0155, 16'h00e1, 16'h00e2, 16'h0103, 16'h00e4, 16'h013a, 16'h0107, 16'h00e7,
		16'h010d, 16'h00e9, 16'h0119, 16'h00eb, 16'h011b, 16'h00ed, 16'h00ee, 16'h010f,
		16'h0111, 16'h0144, 16'h0148, 16'h00f3, 16'h00f4, 16'h0151, 16'h00f6, 16'h00f7,
		16'h0159, 16'h016f, 16'h00fa, 16'h0171, 16'h00fc, 16'h00fd, 16'h0163, 16'h02d9
	};

	// ISO-8859-2 0xA0..0xBF as CP1250
	localparam logic [7:0] LATIN2_HIGH_TO_CP1250 [32] = '{
		8'ha0, 8'ha5, 8'ha2, 8'ha3, 8'ha4, 8'hbc, 8'h8c, 8'ha7,
		8'ha8, 8'h8a, 8'haa, 8'h8d, 8'h8f, 8'had, 8'h8e, 8'haf,
		8'hb0, 8'hb9, 8'hb2, 8'hb3, 8'hb4, 8'hbe, 8'h9c, 8'ha1,
		8'hb8, 8'h9a, 8'hba, 8'h9d, 8'h9f, 8'hbd, 8'h9e, 8'hbf
	};

	typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_e;

	// directed row: a text byte, or a mode write; typed rows carry their one result
	typedef struct packed {
		row_kind_e  kind;
		logic       mode;
		logic [7:0] in_byte;
		logic       text_end;
		logic       typed;
		logic [7:0] typed_byte;
	} dir_row_t;

	localparam int DIR_ROWS = 28;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h41, 1'b0, 1'b1, 8'h41},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h01, 1'b0, 1'b1, 8'h01},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h7f, 1'b0, 1'b1, 8'h7f},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'hc1, 1'b0, 1'b1, QMARK_BYTE},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'hff, 1'b0, 1'b1, QMARK_BYTE},
		// two-byte sequences: no-break space, L with stroke
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'hc2, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'ha0, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'hc5, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h81, 1'b0, 1'b0, 8'h00},
		// euro sign
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'he2, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h82, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'hac, 1'b0, 1'b0, 8'h00},
		// overlong E0 form
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'he0, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h80, 1'b0, 1'b0, 8'h00},
		// bad continuation
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'hc3, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h41, 1'b0, 1'b0, 8'h00},
		// bad third byte: three results from one item
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'he2, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h82, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h41, 1'b0, 1'b0, 8'h00},
		// sequence cut off by the end of text
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'he2, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h82, 1'b1, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'h00, 1'b0, 1'b1, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'hc4, 1'b1, 1'b1, QMARK_BYTE},
		// a held lead meets a switch to ISO-8859-2
		'{ROW_BYTE, u2cp_pkg::MODE_UTF8, 8'he5, 1'b0, 1'b0, 8'h00},
		'{ROW_MODE, u2cp_pkg::MODE_LATIN2, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_LATIN2, 8'h41, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, u2cp_pkg::MODE_LATIN2, 8'ha1, 1'b0, 1'b1, 8'ha5},
		'{ROW_BYTE, u2cp_pkg::MODE_LATIN2, 8'hff, 1'b1, 1'b1, 8'hff}
	};

	typedef struct packed {
		logic mode;
		int   idle_pct;
		int   stall_pct;
		int   items;
	} phase_t;

	localparam int PHASE_COUNT = 7;
	localparam phase_t PHASES [PHASE_COUNT] = '{
		'{u2cp_pkg::MODE_UTF8, 0, 0, 60},
		'{u2cp_pkg::MODE_UTF8, 87, 0, 55},
		'{u2cp_pkg::MODE_LATIN2, 0, 87, 40},
		'{u2cp_pkg::MODE_UTF8, 0, 87, 60},
		'{u2cp_pkg::MODE_UTF8, 19, 19, 60},
		'{u2cp_pkg::MODE_LATIN2, 19, 19, 40},
		'{u2cp_pkg::MODE_UTF8, 0, 0, 90}
	};
	localparam int HOLD_PHASE = 3;
	localparam int PAUSE_PHASE = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	u2cp_pkg::in_item_t src_item = '0;
	logic dst_valid;
	logic dst_stall = 1'b0;
	u2cp_pkg::out_item_t dst_item;

	// typed expectation that travels with the item on offer
	logic src_typed = 1'b0;
	logic [7:0] src_typed_byte = 8'h00;

	// decoder state as the predictor sees it
	logic utf8_mode = u2cp_pkg::MODE_UTF8;
	logic [7:0] held_lead = 8'h00;
	logic [7:0] held_cont = 8'h00;
	logic [1:0] held_count = 2'd0;

	u2cp_pkg::out_item_t cp1250_due [$];
	logic [7:0] text_bytes [$];
	int fault_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;

	utf8_or_latin2_to_cp1250 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item (dst_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic is_cont_byte(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic logic [7:0] point_to_cp1250(input logic [15:0] cp);
		logic [7:0] r;
		r = QMARK_BYTE;
		if (cp < 16'h0080) begin
			r = cp[7:0];
		end else begin
			for (int k = 127; k >= 0; k--) begin
				if (CP1250_CODE_POINTS[k] == cp)
					r = 8'h80 | 8'(k);
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] latin2_to_cp1250(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h80 && b < 8'ha0)
			r = QMARK_BYTE;
		else if (b >= 8'ha0 && b < 8'hc0)
			r = LATIN2_HIGH_TO_CP1250[b[4:0]];
		return r;
	endfunction

	// one text byte in, 0 to 3 CP1250 bytes out; updates the held bytes
	function automatic int transcode_byte(input logic [7:0] b, input logic fin,
			output logic [7:0] outs [3]);
		logic [7:0] seq [3];
		logic [7:0] c;
		int n;
		int pos;
		int cnt;
		int rem;
		logic stop;
		n = 0;
		pos = 0;
		cnt = 0;
		stop = 1'b0;
		outs = '{default: 8'h00};
		seq = '{default: 8'h00};
		if (held_count >= 1) begin
			seq[n] = held_lead;
			n++;
		end
		if (held_count >= 2) begin
			seq[n] = held_cont;
			n++;
		end
		seq[n] = b;
		n++;
		held_count = 2'd0;
		if (utf8_mode == u2cp_pkg::MODE_LATIN2) begin
			// held UTF-8 bytes are flushed as '?'
			while (cnt < n - 1) begin
				outs[cnt] = QMARK_BYTE;
				cnt++;
			end
			outs[cnt] = latin2_to_cp1250(seq[n - 1]);
			cnt++;
			pos = n;
		end else begin
			while (pos < n && !stop) begin
				c = seq[pos];
				rem = n - pos;
				if (c < 8'h80) begin
					outs[cnt] = c;
					cnt++;
					pos++;
				end else if (c < 8'hc2 || c >= 8'hf0) begin
					outs[cnt] = QMARK_BYTE;
					cnt++;
					pos++;
				end else if (c < 8'he0) begin
					if (rem < 2) begin
						stop = 1'b1;
					end else if (is_cont_byte(seq[pos + 1])) begin
						outs[cnt] = point_to_cp1250({5'd0, c[4:0], seq[pos + 1][5:0]});
						cnt++;
						pos += 2;
					end else begin
						outs[cnt] = QMARK_BYTE;
						cnt++;
						pos++;
					end
				end else begin
					// bad or overlong second byte is rejected at once
					if (rem >= 2 && !(is_cont_byte(seq[pos + 1]) &&
							(c >= 8'he1 || seq[pos + 1] >= 8'ha0))) begin
						outs[cnt] = QMARK_BYTE;
						cnt++;
						pos++;
					end else if (rem < 3) begin
						stop = 1'b1;
					end else if (is_cont_byte(seq[pos + 2])) begin
						outs[cnt] = point_to_cp1250({c[3:0], seq[pos + 1][5:0],
							seq[pos + 2][5:0]});
						cnt++;
						pos += 3;
					end else begin
						outs[cnt] = QMARK_BYTE;
						cnt++;
						pos++;
					end
				end
			end
		end
		if (fin) begin
			while (pos < n && cnt < 3) begin
				outs[cnt] = QMARK_BYTE;
				cnt++;
				pos++;
			end
			held_lead = 8'h00;
			held_cont = 8'h00;
		end else begin
			held_lead = (n - pos >= 1) ? seq[pos] : 8'h00;
			held_cont = (n - pos >= 2) ? seq[pos + 1] : 8'h00;
			held_count = 2'(n - pos);
		end
		return cnt;
	endfunction

	function automatic void queue_code_point(input logic [15:0] cp);
		if (cp < 16'h0080) begin
			text_bytes.push_back(cp[7:0]);
		end else if (cp < 16'h0800) begin
			text_bytes.push_back({3'b110, cp[10:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			text_bytes.push_back({4'b1110, cp[15:12]});
			text_bytes.push_back({2'b10, cp[11:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end
	endfunction

	// mostly well-formed characters, some broken sequences and noise
	function automatic void queue_utf8_char();
		int pick;
		logic [7:0] lead;
		pick = $urandom_range(99);
		if (pick < 30) begin
			text_bytes.push_back(8'($urandom_range(1, 127)));
		end else if (pick < 55) begin
			queue_code_point(CP1250_CODE_POINTS[$urandom_range(127)]);
		end else if (pick < 65) begin
			text_bytes.push_back(8'($urandom_range(8'hc2, 8'hdf)));
			text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
		end else if (pick < 75) begin
			lead = 8'($urandom_range(8'he0, 8'hef));
			text_bytes.push_back(lead);
			if (lead == 8'he0)
				text_bytes.push_back(8'($urandom_range(8'ha0, 8'hbf)));
			else
				text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
			text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
		end else if (pick < 87) begin
			lead = 8'($urandom_range(8'hc2, 8'hef));
			text_bytes.push_back(lead);
			if (lead == 8'he0 && $urandom_range(1) == 1) begin
				text_bytes.push_back(8'($urandom_range(8'h80, 8'h9f)));
			end else begin
				if (lead >= 8'he1 && $urandom_range(1) == 1)
					text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				if ($urandom_range(1) == 1)
					text_bytes.push_back(8'($urandom_range(1, 8'h7f)));
				else
					text_bytes.push_back(8'($urandom_range(8'hc0, 8'hff)));
			end
		end else begin
			text_bytes.push_back(8'($urandom_range(1, 255)));
		end
	endfunction

	task automatic note_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// offer one item from a falling edge; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
			input logic [7:0] typed_byte);
		while ($urandom_range(99) < idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_item <= '{in_byte: b, text_end: fin};
		src_typed <= typed;
		src_typed_byte <= typed_byte;
		do
			@(posedge clk);
		while (src_stall);
		@(negedge clk);
	endtask

	// stop offering and wait for every expected result
	task automatic drain();
		src_valid <= 1'b0;
		while (cp1250_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic write_mode(input logic mode);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		utf8_mode = mode;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				dst_stall <= 1'b1;
				hold_left--;
			end else begin
				dst_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// predict on accepted input, check accepted output, watch for a hang
	always @(posedge clk) begin : monitor
		logic [7:0] outs [3];
		int cnt;
		int idle_cycles;
		logic moved;
		u2cp_pkg::out_item_t want;
		u2cp_pkg::out_item_t got;
		if (arst_n) begin
			moved = 1'b0;
			if (src_valid && !src_stall) begin
				moved = 1'b1;
				cnt = transcode_byte(src_item.in_byte, src_item.text_end, outs);
				if (src_typed) begin
					cp1250_due.push_back('{out_byte: src_typed_byte, run_last: 1'b1,
						text_done: src_item.text_end});
				end else begin
					for (int k = 0; k < cnt; k++)
						cp1250_due.push_back('{out_byte: outs[k], run_last: (k == cnt - 1),
							text_done: (k == cnt - 1) && src_item.text_end});
				end
			end
			if (dst_valid && !dst_stall) begin
				moved = 1'b1;
				got = dst_item;
				if (cp1250_due.size() == 0) begin
					note_fault($sformatf("unexpected result byte=%h last=%b done=%b",
						got.out_byte, got.run_last, got.text_done));
				end else begin
					want = cp1250_due.pop_front();
					if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
							got.text_done !== want.text_done)
						note_fault($sformatf(
							"mismatch: expected byte=%h last=%b done=%b, got byte=%h last=%b done=%b",
							want.out_byte, want.run_last, want.text_done,
							got.out_byte, got.run_last, got.text_done));
				end
			end
			if (moved)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("utf8_or_latin2_to_cp1250 verification failed");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	initial begin : stimulus
		int sent;
		logic [7:0] b;
		idle_pct = 19;
		stall_pct = 19;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows; the block starts in UTF-8 mode from reset
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_MODE) begin
				drain();
				write_mode(DIRECTED[i].mode);
			end else begin
				send_byte(DIRECTED[i].in_byte, DIRECTED[i].text_end, DIRECTED[i].typed,
					DIRECTED[i].typed_byte);
			end
		end

		// random phases, each with its own mode and idling mix
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain();
			write_mode(PHASES[p].mode);
			idle_pct = PHASES[p].idle_pct;
			stall_pct = PHASES[p].stall_pct;
			sent = 0;
			while (sent < PHASES[p].items) begin
				if (PHASES[p].mode == u2cp_pkg::MODE_UTF8)
					queue_utf8_char();
				else
					text_bytes.push_back(8'($urandom_range(1, 255)));
				while (text_bytes.size() != 0) begin
					b = text_bytes.pop_front();
					send_byte(b, $urandom_range(99) < END_PCT, 1'b0, 8'h00);
					sent++;
					// long receiver hold-off while items keep coming
					if (p == HOLD_PHASE && sent == 10)
						hold_req = 1'b1;
					// sender pause until the output side has caught up
					if (p == PAUSE_PHASE && sent == 30)
						drain();
				end
			end
		end

		drain();
		repeat (END_GAP) @(negedge clk);
		if (fault_count == 0 && cp1250_due.size() == 0)
			$display("utf8_or_latin2_to_cp1250 verification clean");
		else
			$display("utf8_or_latin2_to_cp1250 verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/u2cp_pkg.sv
rtl/u2cp_front.sv
rtl/u2cp_fifo.sv
rtl/u2cp_back.sv
rtl/utf8_or_latin2_to_cp1250.sv
rtl/u2cp_checker.sv
sim/testbench.sv
